>>> hw/rtl/stage_latency_monitor_macros.svh
// Assertion macros for the stage latency monitor.
// Used by stage_latency_monitor.sv; depends on nothing else.
`ifndef STAGE_LATENCY_MONITOR_MACROS_SVH
`define STAGE_LATENCY_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/slm_pkg.sv
// Shared types and constants for the stage latency monitor.
// Depends on nothing; used by the top level.
package slm_pkg;

    localparam int SEG_COUNT = 5;
    localparam int STAMP_W   = 32;

    localparam logic [2:0] OP_TAP     = 3'd0;
    localparam logic [2:0] OP_REQUEST = 3'd1;
    localparam logic [2:0] OP_PICKUP  = 3'd2;
    localparam logic [2:0] OP_SEND    = 3'd3;
    localparam logic [2:0] OP_SHOW    = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;
    localparam logic [2:0] OP_READ    = 3'd6;

    localparam int SEG_TAP_REQ   = 0;
    localparam int SEG_REQ_PICK  = 1;
    localparam int SEG_PICK_SEND = 2;
    localparam int SEG_SEND_SHOW = 3;
    localparam int SEG_REQ_SHOW  = 4;

    typedef struct packed {
        logic [2:0]         op;
        logic [STAMP_W-1:0] timestamp;
        logic [2:0]         segment_select;
    } t_in_beat;

    typedef struct packed {
        logic [STAMP_W-1:0] last_latency;
        logic [STAMP_W-1:0] max_latency;
        logic [STAMP_W-1:0] sample_count;
        logic               request_busy;
        logic               display_pending;
    } t_out_beat;

endpackage

>>> hw/rtl/slm_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
// The payload type is a parameter, normally a struct from slm_pkg.
interface slm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/stage_latency_monitor.sv
// Stage latency monitor: event timestamps in, segment latency statistics out.
// Depends on slm_pkg, slm_stream_if and stage_latency_monitor_macros.svh.
// Each input beat passes the input register, then its result is registered in the result register.
// Throughput: one beat per cycle while the output is not stalled, set by the input register and result register.
// Reset (synchronous, active low) clears all flags, statistics and valids.
`include "stage_latency_monitor_macros.svh"

module stage_latency_monitor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slm_stream_if.sink   i_in,
    slm_stream_if.source o_out
);

    localparam int NS = slm_pkg::SEG_COUNT;
    localparam int SW = slm_pkg::STAMP_W;

    logic                r_in_valid;
    slm_pkg::t_in_beat   r_in;
    logic                r_out_valid;
    slm_pkg::t_out_beat  r_out;
    slm_pkg::t_out_beat  n_out;

    logic [SW-1:0] r_tap_stamp, n_tap_stamp;
    logic          r_tap_waiting, n_tap_waiting;
    logic [SW-1:0] r_req_stamp, n_req_stamp;
    logic [SW-1:0] r_pick_stamp, n_pick_stamp;
    logic          r_picked, n_picked;
    logic          r_busy, n_busy;
    logic [SW-1:0] r_send_stamp, n_send_stamp;
    logic          r_show, n_show;
    logic [SW-1:0] r_last  [NS];
    logic [SW-1:0] r_max   [NS];
    logic [SW-1:0] r_count [NS];
    logic [SW-1:0] n_last  [NS];
    logic [SW-1:0] n_max   [NS];
    logic [SW-1:0] n_count [NS];

    logic          smp_en  [NS];
    logic [SW-1:0] smp_val [NS];
    logic          advance;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_tap_stamp   = r_tap_stamp;
        n_tap_waiting = r_tap_waiting;
        n_req_stamp   = r_req_stamp;
        n_pick_stamp  = r_pick_stamp;
        n_picked      = r_picked;
        n_busy        = r_busy;
        n_send_stamp  = r_send_stamp;
        n_show        = r_show;
        for (int k = 0; k < NS; k++) begin
            smp_en[k]  = 1'b0;
            smp_val[k] = '0;
        end
        smp_val[slm_pkg::SEG_TAP_REQ]   = r_in.timestamp - r_tap_stamp;
        smp_val[slm_pkg::SEG_REQ_PICK]  = r_in.timestamp - r_req_stamp;
        smp_val[slm_pkg::SEG_PICK_SEND] = r_in.timestamp - r_pick_stamp;
        smp_val[slm_pkg::SEG_SEND_SHOW] = r_in.timestamp - r_send_stamp;
        smp_val[slm_pkg::SEG_REQ_SHOW]  = r_in.timestamp - r_req_stamp;

        case (r_in.op)
            slm_pkg::OP_TAP: begin
                n_tap_stamp   = r_in.timestamp;
                n_tap_waiting = 1'b1;
            end
            slm_pkg::OP_REQUEST: begin
                if (!r_busy) begin
                    n_req_stamp   = r_in.timestamp;
                    n_picked      = 1'b0;
                    n_busy        = 1'b1;
                    n_tap_waiting = 1'b0;
                    smp_en[slm_pkg::SEG_TAP_REQ] = r_tap_waiting;
                end
            end
            slm_pkg::OP_PICKUP: begin
                if (r_busy && !r_picked) begin
                    n_pick_stamp = r_in.timestamp;
                    n_picked     = 1'b1;
                    smp_en[slm_pkg::SEG_REQ_PICK] = 1'b1;
                end
            end
            slm_pkg::OP_SEND: begin
                if (r_busy) begin
                    smp_en[slm_pkg::SEG_PICK_SEND] = r_picked;
                    n_send_stamp = r_in.timestamp;
                    n_show       = 1'b1;
                    n_busy       = 1'b0;
                    n_picked     = 1'b0;
                end
            end
            slm_pkg::OP_SHOW: begin
                if (r_show) begin
                    n_show = 1'b0;
                    smp_en[slm_pkg::SEG_SEND_SHOW] = 1'b1;
                    smp_en[slm_pkg::SEG_REQ_SHOW]  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        for (int k = 0; k < NS; k++) begin
            if (r_in.op == slm_pkg::OP_CLEAR) begin
                n_last[k]  = '0;
                n_max[k]   = '0;
                n_count[k] = '0;
            end else if (smp_en[k]) begin
                n_last[k]  = smp_val[k];
                n_max[k]   = (smp_val[k] > r_max[k]) ? smp_val[k] : r_max[k];
                n_count[k] = r_count[k] + 1'b1;
            end else begin
                n_last[k]  = r_last[k];
                n_max[k]   = r_max[k];
                n_count[k] = r_count[k];
            end
        end

        n_out.request_busy    = n_busy;
        n_out.display_pending = n_show;
        if (r_in.segment_select < 3'(NS)) begin
            n_out.last_latency = n_last[r_in.segment_select];
            n_out.max_latency  = n_max[r_in.segment_select];
            n_out.sample_count = n_count[r_in.segment_select];
        end else begin
            n_out.last_latency = '0;
            n_out.max_latency  = '0;
            n_out.sample_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_tap_waiting <= 1'b0;
            r_picked      <= 1'b0;
            r_busy        <= 1'b0;
            r_show        <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                r_last[k]  <= '0;
                r_max[k]   <= '0;
                r_count[k] <= '0;
            end
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_tap_waiting <= n_tap_waiting;
                r_picked      <= n_picked;
                r_busy        <= n_busy;
                r_show        <= n_show;
                for (int k = 0; k < NS; k++) begin
                    r_last[k]  <= n_last[k];
                    r_max[k]   <= n_max[k];
                    r_count[k] <= n_count[k];
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (advance) begin
            r_out        <= n_out;
            r_tap_stamp  <= n_tap_stamp;
            r_req_stamp  <= n_req_stamp;
            r_pick_stamp <= n_pick_stamp;
            r_send_stamp <= n_send_stamp;
        end
    end

    // A pickup can only be recorded inside an outstanding request.
    `SLM_ASSERT_IMP(a_picked_needs_busy, i_clk, i_rst_n, r_picked, r_busy,
        "picked flag set without an outstanding request")
    // Clearing statistics leaves every sample count at zero.
    `SLM_ASSERT_NXT(a_clear_zeroes, i_clk, i_rst_n,
        advance && (r_in.op == slm_pkg::OP_CLEAR),
        (r_count[0] == '0) && (r_count[1] == '0) && (r_count[2] == '0)
        && (r_count[3] == '0) && (r_count[4] == '0),
        "statistics not cleared")
    // A stalled result holds the statistics and flags unchanged.
    `SLM_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n,
        r_out_valid && !o_out.ready,
        $stable(r_busy) && $stable(r_show) && $stable(r_count[0]),
        "state changed while the result beat was stalled")

endmodule
